@@ rtl/size_class_block_allocator_defines.svh @@
// Assertion macros shared by the size-class block allocator RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("size class allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("size class allocator: next-cycle check failed");

`endif

@@ rtl/scba_pkg.sv @@
// Shared constants, types and size-class tables of the size-class block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package scba_pkg;

  // Pool and chunk configuration.
  localparam int CHUNK_BYTES     = 16384;
  localparam int MAX_CHUNKS      = 64;
  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int NUM_CLASSES     = 16;

  // Field and storage widths.
  localparam int ADDR_W      = 20;
  localparam int SIZE_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int LINK_W      = ADDR_W + 1;
  localparam int LINK_AW     = ADDR_W - 4;
  localparam int CLASS_W     = 4;
  localparam int BS_W        = 13;
  localparam int CHUNKS_W    = $clog2(MAX_CHUNKS + 1);
  localparam int CNT_W       = $clog2(CHUNK_BYTES / 16 + 1);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_ALLOC     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd5;

  // Command codes on the input channel.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Follow-up work that a decided item still needs.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_CARVE
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic exec;
    logic pop_finish;
    logic carve_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    act_t act;
    logic carve_last;
    logic pend_busy;
  } dp_stat_t;

  // Block size of each class in bytes.
  function automatic logic [BS_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    logic [BS_W-1:0] b;
    case (c)
      4'd0:    b = 13'd16;
      4'd1:    b = 13'd32;
      4'd2:    b = 13'd64;
      4'd3:    b = 13'd96;
      4'd4:    b = 13'd128;
      4'd5:    b = 13'd160;
      4'd6:    b = 13'd192;
      4'd7:    b = 13'd224;
      4'd8:    b = 13'd256;
      4'd9:    b = 13'd320;
      4'd10:   b = 13'd384;
      4'd11:   b = 13'd448;
      4'd12:   b = 13'd512;
      4'd13:   b = 13'd1024;
      4'd14:   b = 13'd2048;
      default: b = 13'd4096;
    endcase
    return b;
  endfunction

  // Number of whole blocks of each class in one chunk.
  function automatic logic [CNT_W-1:0] blocks_of(input logic [CLASS_W-1:0] c);
    logic [CNT_W-1:0] n;
    case (c)
      4'd0:    n = CNT_W'(CHUNK_BYTES / 16);
      4'd1:    n = CNT_W'(CHUNK_BYTES / 32);
      4'd2:    n = CNT_W'(CHUNK_BYTES / 64);
      4'd3:    n = CNT_W'(CHUNK_BYTES / 96);
      4'd4:    n = CNT_W'(CHUNK_BYTES / 128);
      4'd5:    n = CNT_W'(CHUNK_BYTES / 160);
      4'd6:    n = CNT_W'(CHUNK_BYTES / 192);
      4'd7:    n = CNT_W'(CHUNK_BYTES / 224);
      4'd8:    n = CNT_W'(CHUNK_BYTES / 256);
      4'd9:    n = CNT_W'(CHUNK_BYTES / 320);
      4'd10:   n = CNT_W'(CHUNK_BYTES / 384);
      4'd11:   n = CNT_W'(CHUNK_BYTES / 448);
      4'd12:   n = CNT_W'(CHUNK_BYTES / 512);
      4'd13:   n = CNT_W'(CHUNK_BYTES / 1024);
      4'd14:   n = CNT_W'(CHUNK_BYTES / 2048);
      default: n = CNT_W'(CHUNK_BYTES / 4096);
    endcase
    return n;
  endfunction

  // Smallest class whose block size is not below the given size. The class
  // sizes rise monotonically, so the class is the number of sizes exceeded.
  function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [NUM_CLASSES-2:0] gt;
    for (int c = 0; c < NUM_CLASSES - 1; c++) begin
      gt[c] = size > {3'b000, class_bytes(CLASS_W'(c))};
    end
    return CLASS_W'($countones(gt));
  endfunction

endpackage

@@ rtl/scba_ctrl.sv @@
// Controller of the size-class block allocator: sequences accept, decision,
// list pop and chunk carving. Depends on scba_pkg.
module scba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  scba_pkg::dp_stat_t  stat,
  output scba_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_CARVE
  } state_t;

  state_t state;

  // An item is taken only when no result is parked in the skid register.
  assign s_tready = (state == ST_IDLE) && !stat.pend_busy;

  // Commands decode straight from the state.
  always_comb begin
    cmd            = '0;
    cmd.take       = s_tvalid && s_tready;
    cmd.exec       = (state == ST_EXEC);
    cmd.pop_finish = (state == ST_POP);
    cmd.carve_step = (state == ST_CARVE);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (stat.act)
            scba_pkg::ACT_POP:   state <= ST_POP;
            scba_pkg::ACT_CARVE: state <= ST_CARVE;
            default:             state <= ST_IDLE;
          endcase
        end
        ST_POP: begin
          state <= ST_IDLE;
        end
        ST_CARVE: begin
          if (stat.carve_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/scba_datapath.sv @@
// Datapath of the size-class block allocator: item register, list heads,
// link memory, chunk carving counters and the result skid. Depends on scba_pkg.
module scba_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [scba_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [scba_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  scba_pkg::ctrl_cmd_t                  cmd,
  output scba_pkg::dp_stat_t                   stat
);

  localparam int AW  = scba_pkg::ADDR_W;
  localparam int LAW = scba_pkg::LINK_AW;
  localparam int LW  = scba_pkg::LINK_W;
  localparam int NC  = scba_pkg::NUM_CLASSES;
  localparam int CW  = scba_pkg::CHUNKS_W;
  localparam int NW  = scba_pkg::CNT_W;
  localparam int SW  = scba_pkg::STATUS_W;

  // Item register.
  logic                        item_cmd;
  logic [scba_pkg::SIZE_W-1:0] item_size;
  logic [AW-1:0]               item_addr;

  // Free-list heads and chunk count.
  logic [NC-1:0]       head_empty;
  logic [AW-1:0]       head_addr [NC];
  logic [CW-1:0]       chunks_used;

  // Link memory.
  logic [LW-1:0]       link_mem [2**LAW];
  logic [LW-1:0]       link_rdata;
  logic                link_we;
  logic [LAW-1:0]      link_waddr;
  logic [LW-1:0]       link_wdata;
  logic [LAW-1:0]      link_raddr;

  // Carving walk.
  logic [AW-1:0]       carve_here;
  logic [NW-1:0]       carve_cnt;
  logic                carve_last;

  // Decision.
  logic [scba_pkg::CLASS_W-1:0] cls;
  logic [scba_pkg::BS_W-1:0]    bs;
  logic [NW-1:0]                count;
  logic                         cur_empty;
  logic [AW-1:0]                cur_head;
  logic [AW-1:0]                base;
  logic                         exhausted;
  scba_pkg::act_t               act;
  logic [AW-1:0]                res_addr;
  logic [SW-1:0]                res_status;

  // Output and skid registers.
  logic                out_valid;
  logic [AW-1:0]       out_addr;
  logic [SW-1:0]       out_status;
  logic                pend_valid;
  logic [AW-1:0]       pend_addr;
  logic [SW-1:0]       pend_status;
  logic                slot_free;

  // Capture the accepted item: size low, address above it; command in tuser.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_cmd  <= s_tuser[0];
      item_size <= s_tdata[scba_pkg::SIZE_W-1:0];
      item_addr <= s_tdata[scba_pkg::SIZE_W +: AW];
    end
  end

  // Class lookup and head selection.
  assign cls       = scba_pkg::class_of(item_size);
  assign bs        = scba_pkg::class_bytes(cls);
  assign count     = scba_pkg::blocks_of(cls);
  assign cur_empty = head_empty[cls];
  assign cur_head  = head_addr[cls];
  assign exhausted = chunks_used >= CW'(scba_pkg::MAX_CHUNKS);
  assign base      = AW'(32'(chunks_used) * 32'(scba_pkg::CHUNK_BYTES));

  // Result and follow-up action of the held item.
  always_comb begin
    act        = scba_pkg::ACT_NONE;
    res_addr   = '0;
    res_status = scba_pkg::STATUS_NULL;
    if (item_size == '0) begin
      res_status = scba_pkg::STATUS_NULL;
    end else if (item_size > scba_pkg::SIZE_W'(scba_pkg::MAX_BLOCK_BYTES)) begin
      res_status = (item_cmd == scba_pkg::CMD_FREE) ? scba_pkg::STATUS_IGNORED
                                                    : scba_pkg::STATUS_TOO_LARGE;
    end else if (item_cmd == scba_pkg::CMD_FREE) begin
      act        = scba_pkg::ACT_PUSH;
      res_status = scba_pkg::STATUS_RELEASED;
    end else if (!cur_empty) begin
      act        = scba_pkg::ACT_POP;
      res_addr   = cur_head;
      res_status = scba_pkg::STATUS_ALLOC;
    end else if (exhausted) begin
      res_status = scba_pkg::STATUS_EXHAUSTED;
    end else begin
      act        = scba_pkg::ACT_CARVE;
      res_addr   = base;
      res_status = scba_pkg::STATUS_ALLOC;
    end
  end

  // Empty flags and chunk count carry reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_empty  <= '1;
      chunks_used <= '0;
    end else if (cmd.exec) begin
      case (act)
        scba_pkg::ACT_PUSH: begin
          head_empty[cls] <= 1'b0;
        end
        scba_pkg::ACT_CARVE: begin
          head_empty[cls] <= (count == NW'(1));
          chunks_used     <= chunks_used + 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.pop_finish) begin
      head_empty[cls] <= link_rdata[AW];
    end
  end

  // Head addresses are payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (act)
        scba_pkg::ACT_PUSH:  head_addr[cls] <= item_addr;
        scba_pkg::ACT_CARVE: head_addr[cls] <= base + AW'(bs);
        default: begin
        end
      endcase
    end else if (cmd.pop_finish) begin
      head_addr[cls] <= link_rdata[AW-1:0];
    end
  end

  // Carving walk: one link written per step.
  assign carve_last = (NW'(carve_cnt + 1'b1) == count);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      carve_here <= base;
      carve_cnt  <= '0;
    end else if (cmd.carve_step) begin
      carve_here <= carve_here + AW'(bs);
      carve_cnt  <= carve_cnt + 1'b1;
    end
  end

  // Link memory write port serves a release push or a carving step.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = item_addr[AW-1:4];
    link_wdata = {cur_empty, cur_head};
    if (cmd.exec && (act == scba_pkg::ACT_PUSH)) begin
      link_we = 1'b1;
    end else if (cmd.carve_step) begin
      link_we    = 1'b1;
      link_waddr = carve_here[AW-1:4];
      link_wdata = carve_last ? {1'b1, {AW{1'b0}}} : {1'b0, carve_here + AW'(bs)};
    end
  end

  assign link_raddr = cur_head[AW-1:4];

  // Link memory with a registered read of the popped head's link.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  // Result register with a one-entry skid behind it.
  assign slot_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.exec) begin
      if (slot_free) begin
        out_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (out_valid && m_tready) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_free) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end else if (cmd.exec) begin
      pend_addr   <= res_addr;
      pend_status <= res_status;
    end else if (out_valid && m_tready && pend_valid) begin
      out_addr   <= pend_addr;
      out_status <= pend_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_status, out_addr};

  // Status towards the controller.
  always_comb begin
    stat            = '0;
    stat.act        = act;
    stat.carve_last = carve_last;
    stat.pend_busy  = pend_valid;
  end

endmodule

@@ rtl/size_class_block_allocator.sv @@
// Size-class block allocator: input stream of alloc and free commands, output
// stream of one result per command, a 65536-link free-list memory behind 16
// list heads. Connects scba_ctrl and scba_datapath; uses scba_pkg and the defines header.
//
// Input transfer: tuser[0] is the command (0 allocate, 1 release); tdata holds
// the byte size in bits 15..0 and the pool address in bits 35..16.
// Output transfer: tdata holds the block address in bits 19..0 and the status
// in bits 22..20 (allocated, released, zero size, too large, exhausted, ignored).
// Every command gives exactly one result, in order.
// The accepted item is registered, then decided in the execute state, and its
// result is registered in the output register. One item is in flight at a time:
// releases, null and error results need only the execute state; an allocate that
// pops a list adds a pop state, since the head's link comes from a registered
// read of the link memory; an allocate on an empty list carves a fresh chunk,
// one link write per cycle for each block of the class (up to 1024).
// Reset empties every list and the chunk count; the link memory is not
// cleared, it is only read at entries written earlier.
// When the receiver stalls, one finished result waits in the output register
// and the next in a skid register; a further input waits until that frees.
`include "size_class_block_allocator_defines.svh"

module size_class_block_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: size[15:0], address[35:16], zero fill[39:36].
  input  logic [scba_pkg::IN_TDATA_W-1:0]      s_tdata,
  // Fields from bit 0: command[0].
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0: address_res[19:0], status[22:20], zero fill[23].
  output logic [scba_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  scba_pkg::ctrl_cmd_t cmd;
  scba_pkg::dp_stat_t  stat;

  // Sequencer.
  scba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Lists, link memory and result registers.
  scba_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Checks: one item in flight, no intake while carving or while the skid is
  // full, and only defined status codes leave the block.
  `SCBA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `SCBA_ASSERT_NOW(a_no_take_while_carving, cmd.carve_step, !s_tready)
  `SCBA_ASSERT_NOW(a_no_take_skid_full, stat.pend_busy, !s_tready)
  `SCBA_ASSERT_NOW(a_status_defined, m_tvalid, m_tdata[22:20] <= scba_pkg::STATUS_IGNORED)

endmodule
